// ===== design/access_matrix_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the access matrix engine
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ACCESS_MATRIX_ENGINE_CORE_ASSERT_SVH
`define ACCESS_MATRIX_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AME_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("access matrix engine: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define AME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("access matrix engine: next-cycle property failed");

`endif

// ===== design/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// Access matrix engine package
// Sizes, request and status codes, and the controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package ame_pkg;

  localparam int MAX_SUBJECTS = 16;
  localparam int MAX_OBJECTS  = 16;
  localparam int NUM_RIGHTS   = 8;

  localparam int ID_W   = 16;
  localparam int REQ_W  = 4;
  localparam int RI_W   = 3;
  localparam int ST_W   = 2;
  localparam int SUBJ_W = $clog2(MAX_SUBJECTS);
  localparam int OBJ_W  = $clog2(MAX_OBJECTS);
  localparam int MAX_SLOTS = (MAX_SUBJECTS > MAX_OBJECTS) ? MAX_SUBJECTS : MAX_OBJECTS;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W = SUBJ_W + OBJ_W;
  localparam int CELL_DEPTH = 1 << ADDR_W;

  localparam int RIGHT_READ  = 0;
  localparam int RIGHT_WRITE = 1;

  localparam logic [REQ_W-1:0] REQ_ADD_OBJ     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_SUBJ    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_OBJ     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_SUBJ    = 4'd3;
  localparam logic [REQ_W-1:0] REQ_GRANT       = 4'd4;
  localparam logic [REQ_W-1:0] REQ_REVOKE      = 4'd5;
  localparam logic [REQ_W-1:0] REQ_CHECK       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_LIST_FREE_O = 4'd7;
  localparam logic [REQ_W-1:0] REQ_LIST_FREE_S = 4'd8;
  localparam logic [REQ_W-1:0] REQ_LIST_FULL_S = 4'd9;
  localparam logic [REQ_W-1:0] REQ_LIST_WRITER = 4'd10;
  localparam logic [REQ_W-1:0] REQ_LIST_ONE_S  = 4'd11;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DECIDE, S_SWEEP, S_CELL_RD, S_CELL_WAIT,
    S_SCAN_CHK, S_SCAN_EV, S_OUTER, S_LIST_END
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_FIND, OP_REVIVE, OP_APPEND, OP_MARK_DEL, OP_SWEEP,
    OP_CELL_RD, OP_CELL_WR, OP_LIST_INIT, OP_SCAN_RD, OP_SCAN_EV, OP_OUTER
  } dp_op_e;

  typedef enum logic [2:0] {
    EM_NONE, EM_SINGLE, EM_CHECK, EM_PEND, EM_FINAL, EM_NOTFOUND
  } emit_e;

  typedef struct packed {
    dp_op_e          op;
    emit_e           emit;
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic find_last;
    logic side_found;
    logic side_del;
    logic side_full;
    logic both_live;
    logic ri_ok;
    logic o_found;
    logic sweep_last;
    logic outer_done;
    logic inner_done;
    logic match;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/ame_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ame_ctrl.sv =====
// ----------------------------------------------------------------------------
// Access matrix engine controller
// Sequences lookup, table updates, cell access and list scans.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire ame_pkg::sts_t sts_i,
  output ame_pkg::cmd_t     cmd_o
);

  ame_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ame_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ame_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ame_pkg::S_FIND;
      end
      ame_pkg::S_FIND: begin
        if (sts_i.find_last) state_d = ame_pkg::S_DECIDE;
      end
      ame_pkg::S_DECIDE: begin
        case (sts_i.req)
          ame_pkg::REQ_ADD_OBJ, ame_pkg::REQ_ADD_SUBJ: begin
            if (sts_i.out_free) begin
              if ((sts_i.side_found && sts_i.side_del) || sts_i.side_full) begin
                state_d = ame_pkg::S_IDLE;
              end else begin
                state_d = ame_pkg::S_SWEEP;
              end
            end
          end
          ame_pkg::REQ_DEL_OBJ, ame_pkg::REQ_DEL_SUBJ: begin
            if (sts_i.out_free) begin
              if (!sts_i.side_found || sts_i.side_del) state_d = ame_pkg::S_IDLE;
              else state_d = ame_pkg::S_SWEEP;
            end
          end
          ame_pkg::REQ_GRANT, ame_pkg::REQ_REVOKE, ame_pkg::REQ_CHECK: begin
            if (sts_i.both_live && sts_i.ri_ok) state_d = ame_pkg::S_CELL_RD;
            else if (sts_i.out_free) state_d = ame_pkg::S_IDLE;
          end
          ame_pkg::REQ_LIST_FREE_O, ame_pkg::REQ_LIST_FREE_S,
          ame_pkg::REQ_LIST_FULL_S, ame_pkg::REQ_LIST_ONE_S: begin
            state_d = ame_pkg::S_SCAN_CHK;
          end
          ame_pkg::REQ_LIST_WRITER: begin
            if (sts_i.o_found) state_d = ame_pkg::S_SCAN_CHK;
            else if (sts_i.out_free) state_d = ame_pkg::S_IDLE;
          end
          default: begin
            if (sts_i.out_free) state_d = ame_pkg::S_IDLE;
          end
        endcase
      end
      ame_pkg::S_SWEEP: begin
        if (sts_i.sweep_last) state_d = ame_pkg::S_IDLE;
      end
      ame_pkg::S_CELL_RD: begin
        state_d = ame_pkg::S_CELL_WAIT;
      end
      ame_pkg::S_CELL_WAIT: begin
        if (sts_i.out_free) state_d = ame_pkg::S_IDLE;
      end
      ame_pkg::S_SCAN_CHK: begin
        if (sts_i.outer_done) state_d = ame_pkg::S_LIST_END;
        else if (sts_i.inner_done) state_d = ame_pkg::S_OUTER;
        else state_d = ame_pkg::S_SCAN_EV;
      end
      ame_pkg::S_SCAN_EV: begin
        state_d = ame_pkg::S_SCAN_CHK;
      end
      ame_pkg::S_OUTER: begin
        if (!(sts_i.match && sts_i.pend_v) || sts_i.out_free) state_d = ame_pkg::S_SCAN_CHK;
      end
      ame_pkg::S_LIST_END: begin
        if (sts_i.out_free) state_d = ame_pkg::S_IDLE;
      end
      default: begin
        state_d = ame_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = ame_pkg::OP_NONE;
    cmd_o.emit = ame_pkg::EM_NONE;
    cmd_o.st   = ame_pkg::ST_DONE;
    case (state_q)
      ame_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = ame_pkg::OP_LATCH;
      end
      ame_pkg::S_FIND: begin
        cmd_o.op = ame_pkg::OP_FIND;
      end
      ame_pkg::S_DECIDE: begin
        case (sts_i.req)
          ame_pkg::REQ_ADD_OBJ, ame_pkg::REQ_ADD_SUBJ: begin
            if (sts_i.out_free) begin
              cmd_o.emit = ame_pkg::EM_SINGLE;
              if (sts_i.side_found && sts_i.side_del) begin
                cmd_o.op = ame_pkg::OP_REVIVE;
              end else if (sts_i.side_full) begin
                cmd_o.st = ame_pkg::ST_FULL;
              end else begin
                cmd_o.op = ame_pkg::OP_APPEND;
              end
            end
          end
          ame_pkg::REQ_DEL_OBJ, ame_pkg::REQ_DEL_SUBJ: begin
            if (sts_i.out_free) begin
              cmd_o.emit = ame_pkg::EM_SINGLE;
              if (!sts_i.side_found || sts_i.side_del) cmd_o.st = ame_pkg::ST_IGNORED;
              else cmd_o.op = ame_pkg::OP_MARK_DEL;
            end
          end
          ame_pkg::REQ_GRANT, ame_pkg::REQ_REVOKE, ame_pkg::REQ_CHECK: begin
            if (!(sts_i.both_live && sts_i.ri_ok) && sts_i.out_free) begin
              cmd_o.emit = ame_pkg::EM_SINGLE;
              cmd_o.st   = ame_pkg::ST_IGNORED;
            end
          end
          ame_pkg::REQ_LIST_FREE_O, ame_pkg::REQ_LIST_FREE_S,
          ame_pkg::REQ_LIST_FULL_S, ame_pkg::REQ_LIST_ONE_S: begin
            cmd_o.op = ame_pkg::OP_LIST_INIT;
          end
          ame_pkg::REQ_LIST_WRITER: begin
            if (sts_i.o_found) begin
              cmd_o.op = ame_pkg::OP_LIST_INIT;
            end else if (sts_i.out_free) begin
              cmd_o.emit = ame_pkg::EM_NOTFOUND;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.emit = ame_pkg::EM_SINGLE;
              cmd_o.st   = ame_pkg::ST_IGNORED;
            end
          end
        endcase
      end
      ame_pkg::S_SWEEP: begin
        cmd_o.op = ame_pkg::OP_SWEEP;
      end
      ame_pkg::S_CELL_RD: begin
        cmd_o.op = ame_pkg::OP_CELL_RD;
      end
      ame_pkg::S_CELL_WAIT: begin
        if (sts_i.out_free) begin
          if (sts_i.req == ame_pkg::REQ_CHECK) begin
            cmd_o.emit = ame_pkg::EM_CHECK;
          end else begin
            cmd_o.op   = ame_pkg::OP_CELL_WR;
            cmd_o.emit = ame_pkg::EM_SINGLE;
          end
        end
      end
      ame_pkg::S_SCAN_CHK: begin
        if (!sts_i.outer_done && !sts_i.inner_done) cmd_o.op = ame_pkg::OP_SCAN_RD;
      end
      ame_pkg::S_SCAN_EV: begin
        cmd_o.op = ame_pkg::OP_SCAN_EV;
      end
      ame_pkg::S_OUTER: begin
        if (sts_i.match && sts_i.pend_v) begin
          if (sts_i.out_free) begin
            cmd_o.op   = ame_pkg::OP_OUTER;
            cmd_o.emit = ame_pkg::EM_PEND;
          end
        end else begin
          cmd_o.op = ame_pkg::OP_OUTER;
        end
      end
      ame_pkg::S_LIST_END: begin
        if (sts_i.out_free) cmd_o.emit = ame_pkg::EM_FINAL;
      end
      default: begin
        cmd_o.op = ame_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ame_dp.sv =====
// ----------------------------------------------------------------------------
// Access matrix engine datapath
// Slot tables, rights cell memory, scan counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ame_pkg::cmd_t                cmd_i,
  output ame_pkg::sts_t                     sts_o,
  input  wire logic [ame_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [ame_pkg::ID_W-1:0]     subject_id_i,
  input  wire logic [ame_pkg::ID_W-1:0]     object_id_i,
  input  wire logic [ame_pkg::RI_W-1:0]     right_index_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [ame_pkg::ST_W-1:0]          status_o,
  output logic                              right_present_o,
  output logic [ame_pkg::ID_W-1:0]          listed_id_o,
  output logic                              list_empty_o,
  output logic                              last_o
);

  localparam int SW = ame_pkg::SUBJ_W;
  localparam int OW = ame_pkg::OBJ_W;
  localparam int CW = ame_pkg::CNT_W;
  localparam int RW = ame_pkg::NUM_RIGHTS;

  // Request fields.
  logic [ame_pkg::REQ_W-1:0] req_q;
  logic [ame_pkg::ID_W-1:0]  sid_q, oid_q;
  logic [ame_pkg::RI_W-1:0]  ri_q;

  // Slot tables.
  logic [ame_pkg::ID_W-1:0] subj_ids_q [ame_pkg::MAX_SUBJECTS];
  logic [ame_pkg::ID_W-1:0] obj_ids_q  [ame_pkg::MAX_OBJECTS];
  logic [ame_pkg::MAX_SUBJECTS-1:0] subj_del_q;
  logic [ame_pkg::MAX_OBJECTS-1:0]  obj_del_q;
  logic [CW-1:0] scnt_q, ocnt_q;

  // Lookup and scan state.
  logic [CW-1:0] k_q, a_q, b_q, line_q;
  logic          s_hit_q, o_hit_q;
  logic [SW-1:0] s_idx_q;
  logic [OW-1:0] o_idx_q;
  logic          any_q, allf_q;
  logic [1:0]    hits_q;
  logic          pend_v_q;
  logic [ame_pkg::ID_W-1:0] pend_id_q;

  // Result register.
  logic out_v_q;

  // Cell memory port.
  logic                       ram_we, ram_re;
  logic [ame_pkg::ADDR_W-1:0] ram_addr;
  logic [RW-1:0]              ram_wdata, ram_rdata;

  logic          is_obj, is_lst_o, is_wr;
  logic [CW-1:0] outer_cnt, inner_cnt;
  logic [RW-1:0] bit_mask;
  logic          cell_nz, cell_full, match;
  logic [ame_pkg::ID_W-1:0] outer_id;
  logic          out_free;

  assign is_obj   = (req_q == ame_pkg::REQ_ADD_OBJ) || (req_q == ame_pkg::REQ_DEL_OBJ);
  assign is_lst_o = (req_q == ame_pkg::REQ_LIST_FREE_O);
  assign is_wr    = (req_q == ame_pkg::REQ_LIST_WRITER);
  assign outer_cnt = is_lst_o ? ocnt_q : scnt_q;
  assign inner_cnt = is_lst_o ? scnt_q : (is_wr ? CW'(1) : ocnt_q);
  assign bit_mask  = RW'(1) << ri_q;
  assign out_free  = !out_v_q || out_ready_i;

  assign cell_nz   = is_wr ? ram_rdata[ame_pkg::RIGHT_WRITE] : (|ram_rdata);
  assign cell_full = ram_rdata[ame_pkg::RIGHT_READ] && ram_rdata[ame_pkg::RIGHT_WRITE];
  assign outer_id  = is_lst_o ? obj_ids_q[a_q[OW-1:0]] : subj_ids_q[a_q[SW-1:0]];

  always_comb begin
    case (req_q)
      ame_pkg::REQ_LIST_FULL_S: match = allf_q;
      ame_pkg::REQ_LIST_WRITER: match = any_q;
      ame_pkg::REQ_LIST_ONE_S:  match = (hits_q == 2'd1);
      default:                  match = !any_q;
    endcase
  end

  // Memory access steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = {s_idx_q, o_idx_q};
    ram_wdata = '0;
    case (cmd_i.op)
      ame_pkg::OP_SWEEP: begin
        ram_we   = 1'b1;
        ram_addr = is_obj ? {b_q[SW-1:0], line_q[OW-1:0]} : {line_q[SW-1:0], b_q[OW-1:0]};
      end
      ame_pkg::OP_CELL_RD: begin
        ram_re = 1'b1;
      end
      ame_pkg::OP_CELL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (req_q == ame_pkg::REQ_GRANT) ? (ram_rdata | bit_mask)
                                                  : (ram_rdata & ~bit_mask);
      end
      ame_pkg::OP_SCAN_RD: begin
        ram_re = 1'b1;
        if (is_lst_o) ram_addr = {b_q[SW-1:0], a_q[OW-1:0]};
        else if (is_wr) ram_addr = {a_q[SW-1:0], o_idx_q};
        else ram_addr = {a_q[SW-1:0], b_q[OW-1:0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ame_ram #(
    .WIDTH (RW),
    .DEPTH (ame_pkg::CELL_DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ame_pkg::OP_LATCH) begin
      req_q <= req_type_i;
      sid_q <= subject_id_i;
      oid_q <= object_id_i;
      ri_q  <= right_index_i;
    end
    if (cmd_i.op == ame_pkg::OP_APPEND) begin
      if (is_obj) obj_ids_q[ocnt_q[OW-1:0]] <= oid_q;
      else subj_ids_q[scnt_q[SW-1:0]] <= sid_q;
    end
    if (cmd_i.op == ame_pkg::OP_FIND) begin
      if ((k_q < scnt_q) && !s_hit_q && (subj_ids_q[k_q[SW-1:0]] == sid_q)) begin
        s_idx_q <= k_q[SW-1:0];
      end
      if ((k_q < ocnt_q) && !o_hit_q && (obj_ids_q[k_q[OW-1:0]] == oid_q)) begin
        o_idx_q <= k_q[OW-1:0];
      end
    end
    if ((cmd_i.op == ame_pkg::OP_OUTER) && match) begin
      pend_id_q <= outer_id;
    end
    if (cmd_i.emit != ame_pkg::EM_NONE) begin
      status_o        <= ame_pkg::ST_DONE;
      right_present_o <= 1'b0;
      listed_id_o     <= '0;
      list_empty_o    <= 1'b0;
      last_o          <= 1'b1;
      case (cmd_i.emit)
        ame_pkg::EM_SINGLE: status_o <= cmd_i.st;
        ame_pkg::EM_CHECK:  right_present_o <= |(ram_rdata & bit_mask);
        ame_pkg::EM_PEND: begin
          listed_id_o <= pend_id_q;
          last_o      <= 1'b0;
        end
        ame_pkg::EM_FINAL: begin
          if (pend_v_q) listed_id_o <= pend_id_q;
          else list_empty_o <= 1'b1;
        end
        ame_pkg::EM_NOTFOUND: begin
          status_o     <= ame_pkg::ST_IGNORED;
          list_empty_o <= 1'b1;
        end
        default: status_o <= ame_pkg::ST_DONE;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subj_del_q <= '0;
      obj_del_q  <= '0;
      scnt_q     <= '0;
      ocnt_q     <= '0;
      k_q        <= '0;
      a_q        <= '0;
      b_q        <= '0;
      line_q     <= '0;
      s_hit_q    <= 1'b0;
      o_hit_q    <= 1'b0;
      any_q      <= 1'b0;
      allf_q     <= 1'b1;
      hits_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        ame_pkg::OP_LATCH: begin
          k_q     <= '0;
          s_hit_q <= 1'b0;
          o_hit_q <= 1'b0;
        end
        ame_pkg::OP_FIND: begin
          if ((k_q < scnt_q) && (subj_ids_q[k_q[SW-1:0]] == sid_q)) s_hit_q <= 1'b1;
          if ((k_q < ocnt_q) && (obj_ids_q[k_q[OW-1:0]] == oid_q)) o_hit_q <= 1'b1;
          k_q <= k_q + CW'(1);
        end
        ame_pkg::OP_REVIVE: begin
          if (is_obj) obj_del_q[o_idx_q] <= 1'b0;
          else subj_del_q[s_idx_q] <= 1'b0;
        end
        ame_pkg::OP_APPEND: begin
          b_q <= '0;
          if (is_obj) begin
            obj_del_q[ocnt_q[OW-1:0]] <= 1'b0;
            line_q <= ocnt_q;
            ocnt_q <= ocnt_q + CW'(1);
          end else begin
            subj_del_q[scnt_q[SW-1:0]] <= 1'b0;
            line_q <= scnt_q;
            scnt_q <= scnt_q + CW'(1);
          end
        end
        ame_pkg::OP_MARK_DEL: begin
          b_q <= '0;
          if (is_obj) begin
            obj_del_q[o_idx_q] <= 1'b1;
            line_q <= CW'(o_idx_q);
          end else begin
            subj_del_q[s_idx_q] <= 1'b1;
            line_q <= CW'(s_idx_q);
          end
        end
        ame_pkg::OP_SWEEP: begin
          b_q <= b_q + CW'(1);
        end
        ame_pkg::OP_LIST_INIT: begin
          a_q      <= '0;
          b_q      <= '0;
          any_q    <= 1'b0;
          allf_q   <= 1'b1;
          hits_q   <= '0;
          pend_v_q <= 1'b0;
        end
        ame_pkg::OP_SCAN_EV: begin
          if (cell_nz) any_q <= 1'b1;
          if (cell_full) begin
            if (hits_q != 2'd2) hits_q <= hits_q + 2'd1;
          end else begin
            allf_q <= 1'b0;
          end
          b_q <= b_q + CW'(1);
        end
        ame_pkg::OP_OUTER: begin
          if (match) pend_v_q <= 1'b1;
          a_q    <= a_q + CW'(1);
          b_q    <= '0;
          any_q  <= 1'b0;
          allf_q <= 1'b1;
          hits_q <= '0;
        end
        default: begin
          k_q <= k_q;
        end
      endcase
      if (cmd_i.emit != ame_pkg::EM_NONE) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;

  always_comb begin
    sts_o.req        = req_q;
    sts_o.find_last  = (k_q == CW'(ame_pkg::MAX_SLOTS - 1));
    sts_o.side_found = is_obj ? o_hit_q : s_hit_q;
    sts_o.side_del   = is_obj ? obj_del_q[o_idx_q] : subj_del_q[s_idx_q];
    sts_o.side_full  = is_obj ? (ocnt_q == CW'(ame_pkg::MAX_OBJECTS))
                              : (scnt_q == CW'(ame_pkg::MAX_SUBJECTS));
    sts_o.both_live  = s_hit_q && o_hit_q && !subj_del_q[s_idx_q] && !obj_del_q[o_idx_q];
    sts_o.ri_ok      = (int'(ri_q) < ame_pkg::NUM_RIGHTS);
    sts_o.o_found    = o_hit_q;
    sts_o.sweep_last = is_obj ? (b_q == CW'(ame_pkg::MAX_SUBJECTS - 1))
                              : (b_q == CW'(ame_pkg::MAX_OBJECTS - 1));
    sts_o.outer_done = (a_q >= outer_cnt);
    sts_o.inner_done = (b_q >= inner_cnt);
    sts_o.match      = match;
    sts_o.pend_v     = pend_v_q;
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

// ===== design/access_matrix_engine_core.sv =====
// ----------------------------------------------------------------------------
// Access matrix engine core
// Subject and object slot tables with a matrix of rights masks.
// ----------------------------------------------------------------------------
// A serial id lookup and a decide step put out a single result word for each
// non-list request; grant, revoke and check of two live slots first read the cell.
// The next request is taken only once the last one is done; adds of a new slot and
// deletes of a live slot clear a 16-cell row or column after their word. A list
// query reads each cell in a check step and then an evaluate step, and output
// stalls hold it up. Async active-low reset empties the tables.
`default_nettype none

module access_matrix_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: subject_id[15:0], object_id[31:16], right_index[34:32],
  // zero fill [39:35].
  input  wire logic [39:0] s_axis_tdata,
  // tuser: req_type[3:0].
  input  wire logic [3:0]  s_axis_tuser,
  // Result channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, low bit up: status[1:0], right_present[2], listed_id[18:3],
  // list_empty[19], zero fill [23:20].
  output logic [23:0]      m_axis_tdata,
  // tlast: last word of the results of one request.
  output logic             m_axis_tlast
);

  ame_pkg::cmd_t cmd;
  ame_pkg::sts_t sts;

  logic [ame_pkg::ST_W-1:0] status;
  logic                     right_present;
  logic [ame_pkg::ID_W-1:0] listed_id;
  logic                     list_empty;

  // The controller only talks to the datapath through cmd and sts.
  ame_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ame_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser),
    .subject_id_i    (s_axis_tdata[15:0]),
    .object_id_i     (s_axis_tdata[31:16]),
    .right_index_i   (s_axis_tdata[34:32]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (status),
    .right_present_o (right_present),
    .listed_id_o     (listed_id),
    .list_empty_o    (list_empty),
    .last_o          (m_axis_tlast)
  );

  // Pack the result word; the top nibble is zero fill.
  assign m_axis_tdata = {4'b0000, list_empty, listed_id, right_present, status};

endmodule

`default_nettype wire

// ===== design/ame_checker.sv =====
// ----------------------------------------------------------------------------
// Access matrix engine port checker
// Watches the top-level ports and flags broken result sequences.
// ----------------------------------------------------------------------------
`default_nettype none

`include "access_matrix_engine_core_assert.svh"

module ame_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A word waiting at the output stays offered.
  `AME_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // After taking a request the engine is busy with its lookup.
  `AME_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // An empty-list word is always the only and final word of its request.
  `AME_ASSERT_SAME(a_empty_is_last, m_axis_tvalid && m_axis_tdata[19], m_axis_tlast)
  // Status code three is never produced.
  `AME_ASSERT_SAME(a_status_legal, m_axis_tvalid, m_axis_tdata[1:0] != 2'b11)

endmodule

bind access_matrix_engine_core ame_checker u_ame_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
